// ----- rtl/switch_temp_sensor_conditioner_assert.svh -----
// ----------------------------------------------------------------------------
// Temperature sensor conditioner assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SWITCH_TEMP_SENSOR_CONDITIONER_ASSERT_SVH
`define SWITCH_TEMP_SENSOR_CONDITIONER_ASSERT_SVH

// same-cycle implication
`define STSC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/stsc_pkg.sv -----
// ----------------------------------------------------------------------------
// stsc_pkg
// Types and constants shared by the temperature sensor conditioner.
// ----------------------------------------------------------------------------
package stsc_pkg;

    localparam int ACC_W         = 64;   // Horner accumulator width
    localparam int TEMP_W        = 9;    // whole-degree output width
    localparam int HOLD_W        = 8;
    localparam int MID_SHIFT     = 20;   // scale 2^-60 -> 2^-40 before last step
    localparam int ACC_FRAC      = 40;   // fraction bits of the final sum
    localparam int STATUS_OK_BIT = 7;
    localparam int DEG_MAX       = 255;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd20;

    // polynomial coefficients, scale 2^-60 (index 0 at scale 2^-40)
    localparam logic signed [ACC_W-1:0] C4_NEG = -64'sd52614726;
    localparam logic signed [ACC_W-1:0] COEF [4] = '{
        -64'sd58833767690666,
         64'sd375817822856695808,
        -64'sd271593718841344,
         64'sd165225180825
    };

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL,
        OP_ADD,
        OP_SHIFT,
        OP_ROUND
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_SHIFT,
        ST_ROUND,
        ST_POST
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] coef_sel;
    } ctl_t;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [7:0] low_byte;
        logic       bus_failed;
    } in_item_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature_deg;
        logic                     reading_ok;
        logic                     value_held;
    } out_item_t;

endpackage

// ----- rtl/stsc_seq.sv -----
// ----------------------------------------------------------------------------
// stsc_seq
// Sequencer that steps the shared multiply-add unit through the Horner scheme.
// ----------------------------------------------------------------------------
module stsc_seq
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          start_fail,
    input  logic          out_free,
    output stsc_pkg::ctl_t ctl,
    output logic          busy,
    output logic          fire
);

    stsc_pkg::state_t state_reg;
    stsc_pkg::state_t state_next;
    logic [1:0]       step_reg;
    logic [1:0]       step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stsc_pkg::ST_IDLE;
            step_reg  <= 2'd3;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            stsc_pkg::ST_IDLE:
            begin
                step_next = 2'd3;
                if (start)
                begin
                    state_next = start_fail ? stsc_pkg::ST_POST : stsc_pkg::ST_MUL;
                end
            end
            stsc_pkg::ST_MUL:
            begin
                state_next = stsc_pkg::ST_ADD;
            end
            stsc_pkg::ST_ADD:
            begin
                step_next = step_reg - 2'd1;
                if (step_reg == 2'd0)
                begin
                    state_next = stsc_pkg::ST_ROUND;
                end
                else if (step_reg == 2'd1)
                begin
                    state_next = stsc_pkg::ST_SHIFT;
                end
                else
                begin
                    state_next = stsc_pkg::ST_MUL;
                end
            end
            stsc_pkg::ST_SHIFT:
            begin
                state_next = stsc_pkg::ST_MUL;
            end
            stsc_pkg::ST_ROUND:
            begin
                state_next = stsc_pkg::ST_POST;
            end
            stsc_pkg::ST_POST:
            begin
                if (out_free)
                begin
                    state_next = stsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stsc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl.op       = stsc_pkg::OP_NONE;
        ctl.coef_sel = step_reg;
        busy         = 1'b1;
        fire         = 1'b0;
        unique case (state_reg)
            stsc_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctl.op = stsc_pkg::OP_LOAD;
                end
            end
            stsc_pkg::ST_MUL:   ctl.op = stsc_pkg::OP_MUL;
            stsc_pkg::ST_ADD:   ctl.op = stsc_pkg::OP_ADD;
            stsc_pkg::ST_SHIFT: ctl.op = stsc_pkg::OP_SHIFT;
            stsc_pkg::ST_ROUND: ctl.op = stsc_pkg::OP_ROUND;
            stsc_pkg::ST_POST:  fire   = out_free;
            default:            ctl.op = stsc_pkg::OP_NONE;
        endcase
    end

endmodule

// ----- rtl/stsc_horner.sv -----
// ----------------------------------------------------------------------------
// stsc_horner
// Shared multiply-add unit: accumulator times code, plus coefficient; it also loads, shifts and rounds.
// ----------------------------------------------------------------------------
module stsc_horner
#(
    parameter int CODE_BITS = 10,
    parameter int FRAC_BITS = 8
)
(
    input  logic                              clk,
    input  stsc_pkg::ctl_t                    ctl,
    input  logic [CODE_BITS-1:0]              code,
    output logic signed [stsc_pkg::ACC_W-1:0] acc
);

    localparam int    ROUND_SHIFT = stsc_pkg::ACC_FRAC - FRAC_BITS;
    localparam longint ROUND_HALF = longint'(1) << (ROUND_SHIFT - 1);

    logic signed [stsc_pkg::ACC_W-1:0]       acc_reg;
    logic signed [stsc_pkg::ACC_W-1:0]       acc_next;
    logic signed [stsc_pkg::ACC_W-1:0]       prod_reg;
    logic signed [stsc_pkg::ACC_W+CODE_BITS:0] prod_full;

    assign prod_full = acc_reg * $signed({1'b0, code});

    always_comb
    begin
        acc_next = acc_reg;
        unique case (ctl.op)
            stsc_pkg::OP_LOAD:  acc_next = stsc_pkg::C4_NEG;
            stsc_pkg::OP_ADD:   acc_next = prod_reg + stsc_pkg::COEF[ctl.coef_sel];
            stsc_pkg::OP_SHIFT: acc_next = acc_reg >>> stsc_pkg::MID_SHIFT;
            stsc_pkg::OP_ROUND: acc_next = (acc_reg + ROUND_HALF) >>> ROUND_SHIFT;
            default:            acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (ctl.op == stsc_pkg::OP_MUL)
        begin
            prod_reg <= prod_full[stsc_pkg::ACC_W-1:0];
        end
    end

    assign acc = acc_reg;

endmodule

// ----- rtl/stsc_post.sv -----
// ----------------------------------------------------------------------------
// stsc_post
// Range check, last-good hold, hold counter and whole-degree output.
// ----------------------------------------------------------------------------
module stsc_post
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [stsc_pkg::HOLD_W-1:0]       cfg_data,
    input  logic signed [stsc_pkg::ACC_W-1:0] acc,
    input  logic                              fail,
    input  logic                              fire,
    output stsc_pkg::out_item_t               result
);

    localparam int T_W = FRAC_BITS + stsc_pkg::TEMP_W;
    localparam longint T_MIN = -(longint'(1) << FRAC_BITS);
    localparam longint T_MAX = longint'(stsc_pkg::DEG_MAX) << FRAC_BITS;
    localparam logic signed [T_W-1:0] ONE_DEG = T_W'(1) << FRAC_BITS;
    localparam logic signed [T_W-1:0] NEG_ONE = -ONE_DEG;

    logic signed [T_W-1:0]          last_in_range_reg;
    logic signed [T_W-1:0]          last_positive_reg;
    logic [stsc_pkg::HOLD_W-1:0]    hold_counter_reg;
    logic [stsc_pkg::HOLD_W-1:0]    hold_limit_reg;

    logic                           out_of_range;
    logic signed [T_W-1:0]          t_sel;
    logic                           t_pos;
    logic                           hold_live;
    logic signed [T_W-1:0]          t_out;
    logic                           t_neg;
    logic [T_W-1:0]                 t_mag;
    logic [stsc_pkg::TEMP_W-1:0]    deg_mag;

    assign out_of_range = (acc < T_MIN) || (acc > T_MAX);

    always_comb
    begin
        if (fail)
        begin
            t_sel = NEG_ONE;
        end
        else if (out_of_range)
        begin
            t_sel = last_in_range_reg;
        end
        else
        begin
            t_sel = acc[T_W-1:0];
        end
    end

    assign t_pos     = !t_sel[T_W-1] && (|t_sel);
    assign hold_live = (hold_counter_reg != '0);
    assign t_out     = (!t_pos && hold_live) ? last_positive_reg : t_sel;

    // truncate toward zero
    assign t_neg   = t_out[T_W-1];
    assign t_mag   = t_neg ? T_W'(-t_out) : T_W'(t_out);
    assign deg_mag = t_mag[T_W-1:FRAC_BITS];

    assign result.temperature_deg = t_neg ? -deg_mag : deg_mag;
    assign result.reading_ok      = !fail && (t_sel > NEG_ONE);
    assign result.value_held      = !t_pos && hold_live;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_in_range_reg <= '0;
            last_positive_reg <= '0;
            hold_counter_reg  <= stsc_pkg::HOLD_RESET;
            hold_limit_reg    <= stsc_pkg::HOLD_RESET;
        end
        else
        begin
            if (cfg_write)
            begin
                hold_limit_reg <= cfg_data;
            end
            if (fire)
            begin
                if (!fail && !out_of_range)
                begin
                    last_in_range_reg <= acc[T_W-1:0];
                end
                if (t_pos)
                begin
                    last_positive_reg <= t_sel;
                    hold_counter_reg  <= hold_limit_reg;
                end
                else if (hold_live)
                begin
                    hold_counter_reg <= hold_counter_reg - 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/switch_temp_sensor_conditioner.sv -----
// A good read runs through the Horner steps before its result is registered; a failed
// read skips to the output step. Items are taken one at a time; the shared multiply-add
// unit runs four multiply and four add steps plus a shift and a rounding step.
// A result waiting on a stalled output holds the sequencer in its last step.
// Reset (rst_n, async low) clears the stored readings, sets hold limit and
// hold counter to 20 and empties the output register.
// ----------------------------------------------------------------------------
// switch_temp_sensor_conditioner
// Converts a sensor read response into whole degrees with hold-over of the
// last positive reading.
// ----------------------------------------------------------------------------
module switch_temp_sensor_conditioner
#(
    parameter int CODE_BITS = 10,
    parameter int FRAC_BITS = 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  stsc_pkg::in_item_t          in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output stsc_pkg::out_item_t         out_data,
    input  logic                        cfg_write,
    input  logic [stsc_pkg::HOLD_W-1:0] cfg_data
);

    logic                              accept;
    logic                              fail_now;
    logic [15:0]                       raw_code;
    logic [CODE_BITS-1:0]              code_reg;
    logic                              fail_reg;
    logic                              out_valid_reg;
    stsc_pkg::out_item_t               out_data_reg;
    logic                              out_free;
    logic                              fire;
    logic                              busy;
    stsc_pkg::ctl_t                    ctl;
    logic signed [stsc_pkg::ACC_W-1:0] acc;
    stsc_pkg::out_item_t               result;

    assign accept   = in_valid && !busy;
    assign in_stall = busy;
    assign fail_now = in_data.bus_failed || !in_data.status_byte[stsc_pkg::STATUS_OK_BIT];
    assign raw_code = {in_data.status_byte, in_data.low_byte};
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_reg <= raw_code[CODE_BITS-1:0];
            fail_reg <= fail_now;
        end
        if (fire)
        begin
            out_data_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    stsc_seq u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_valid),
        .start_fail (fail_now),
        .out_free   (out_free),
        .ctl        (ctl),
        .busy       (busy),
        .fire       (fire)
    );

    stsc_horner #(
        .CODE_BITS (CODE_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_horner
    (
        .clk  (clk),
        .ctl  (ctl),
        .code (code_reg),
        .acc  (acc)
    );

    stsc_post #(
        .FRAC_BITS (FRAC_BITS)
    ) u_post
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .acc       (acc),
        .fail      (fail_reg),
        .fire      (fire),
        .result    (result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/stsc_checker.sv -----
// ----------------------------------------------------------------------------
// stsc_checker
// Port-level checks of the temperature sensor conditioner.
// ----------------------------------------------------------------------------
`include "switch_temp_sensor_conditioner_assert.svh"

module stsc_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input stsc_pkg::out_item_t         out_data
);

    logic in_take;
    logic out_wait;
    logic good_or_held;
    logic temp_neg;

    assign in_take      = in_valid && !in_stall;
    assign out_wait     = out_valid && out_stall;
    assign good_or_held = out_valid && (out_data.value_held || out_data.reading_ok);
    assign temp_neg     = out_data.temperature_deg[stsc_pkg::TEMP_W-1];

    // one item at a time: busy right after an item is taken
    `STSC_ASSERT_NEXT(a_busy_after_accept, in_take, in_stall, "not busy after accept")

    `STSC_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_data), "item changed")

    // a result only follows an item in progress
    `STSC_ASSERT_IMPL(a_result_from_item, $rose(out_valid), $past(in_stall), "result without item")

    // held values and good readings are never below zero
    `STSC_ASSERT_IMPL(a_nonneg, good_or_held, !temp_neg, "negative good or held value")

endmodule

bind switch_temp_sensor_conditioner stsc_checker u_stsc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ----- test/tb_switch_temp_sensor_conditioner.sv -----
// ----------------------------------------------------------------------------
// tb_switch_temp_sensor_conditioner
// Drives sensor read responses through the conditioner with random sender
// bursts and receiver stalls, predicts each result with a fixed-point model
// of the polynomial conversion and hold-over logic, and checks every field.
// ----------------------------------------------------------------------------
module tb_switch_temp_sensor_conditioner;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CODE_BITS      = 10;
    localparam int FRAC_BITS      = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // polynomial coefficients at scale 2^-60 (K0 at 2^-40), rounded to nearest (K2, K1 before the 4096 scaling)
    localparam longint K4 = longint'(((64'd45636 << 45) + 64'd30517578125 / 2)
                                     / 64'd30517578125);
    localparam longint K3 = longint'(((64'd14331 << 49) + 64'd48828125 / 2)
                                     / 64'd48828125);
    localparam longint K2 = longint'(((64'd23557 << 40) + 64'd390625 / 2)
                                     / 64'd390625) * 4096;
    localparam longint K1 = longint'(((64'd32597 << 43) + 64'd3125 / 2)
                                     / 64'd3125) * 4096;
    localparam longint K0 = longint'(((64'd53509 << 37) + 64'd125 / 2) / 64'd125);
    localparam longint ONE_DEG   = longint'(1) <<< FRAC_BITS;
    localparam longint CODE_MASK = (longint'(1) <<< CODE_BITS) - 1;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    stsc_pkg::in_item_t            in_data   = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    stsc_pkg::out_item_t           out_data;
    logic                          cfg_write = 1'b0;
    logic [stsc_pkg::HOLD_W-1:0]   cfg_data  = '0;

    stsc_pkg::in_item_t  pending_reads[$];
    stsc_pkg::out_item_t expected_readings[$];

    // predictor state
    logic [stsc_pkg::HOLD_W-1:0] hold_lim        = stsc_pkg::HOLD_RESET;
    logic [stsc_pkg::HOLD_W-1:0] hold_left       = stsc_pkg::HOLD_RESET;
    longint                      last_in_range_t = 0;
    longint                      last_pos_t      = 0;

    int errors       = 0;
    int stuck_cycles = 0;

    wire in_fire  = in_valid && !in_stall;
    wire out_fire = out_valid && !out_stall;

    switch_temp_sensor_conditioner #(
        .CODE_BITS (CODE_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic longint code_to_fixed(input longint n);
        longint s3, s2, s1, r;
        s3 = -K4 * n + K3;
        s2 = s3 * n - K2;
        s1 = s2 * n + K1;
        r  = (s1 >>> stsc_pkg::MID_SHIFT) * n - K0
             + (longint'(1) <<< (stsc_pkg::ACC_FRAC - 1 - FRAC_BITS));
        return r >>> (stsc_pkg::ACC_FRAC - FRAC_BITS);
    endfunction

    function automatic longint to_whole_deg(input longint t);
        if (t >= 0)
            return t >>> FRAC_BITS;
        return -((-t) >>> FRAC_BITS);
    endfunction

    function automatic stsc_pkg::out_item_t predict_reading(input stsc_pkg::in_item_t rd);
        stsc_pkg::out_item_t res;
        longint              t;
        longint              code;
        longint              deg;
        logic                ok;
        logic                held;
        ok   = 1'b0;
        held = 1'b0;
        if (rd.bus_failed || !rd.status_byte[stsc_pkg::STATUS_OK_BIT])
            t = -ONE_DEG;
        else
        begin
            code = longint'({rd.status_byte, rd.low_byte}) & CODE_MASK;
            t = code_to_fixed(code);
            if (t < -ONE_DEG || t > stsc_pkg::DEG_MAX * ONE_DEG)
                t = last_in_range_t;
            else
                last_in_range_t = t;
            ok = to_whole_deg(t) >= 0;
        end
        if (t > 0)
        begin
            last_pos_t = t;
            hold_left  = hold_lim;
        end
        else if (hold_left > 0)
        begin
            t    = last_pos_t;
            held = 1'b1;
            hold_left--;
        end
        deg = to_whole_deg(t);
        res.temperature_deg = deg[stsc_pkg::TEMP_W-1:0];
        res.reading_ok      = ok;
        res.value_held      = held;
        return res;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && cfg_write)
            hold_lim = cfg_data;
        if (rst_n && in_fire)
            expected_readings.push_back(predict_reading(in_data));
    end

    // ------------------------------------------------------------------
    // driver: bursts of items with random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_reads.size() > 0)
            begin
                in_data  <= pending_reads.pop_front();
                in_valid <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 40);
                    // a third of the bursts run back to back
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // receiver stall pattern: free-running, random, or long stall runs
    // ------------------------------------------------------------------
    int stall_mode      = 0;
    int stall_mode_left = 0;
    int stall_run       = 0;

    always @(posedge clk)
    begin
        logic nxt;
        nxt = 1'b0;
        if (stall_mode_left == 0)
        begin
            stall_mode      <= $urandom_range(0, 2);
            stall_mode_left <= $urandom_range(50, 300);
        end
        else
            stall_mode_left <= stall_mode_left - 1;
        case (stall_mode)
            0: nxt = 1'b0;
            1: nxt = ($urandom_range(0, 1) == 1);
            default:
            begin
                if (stall_run > 0)
                begin
                    nxt = 1'b1;
                    stall_run <= stall_run - 1;
                end
                else if ($urandom_range(0, 3) == 0)
                    stall_run <= $urandom_range(1, 20);
            end
        endcase
        out_stall <= nxt;
    end

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        stsc_pkg::out_item_t want;
        if (rst_n && out_fire)
        begin
            if (expected_readings.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: temp %0d ok %0b held %0b",
                             out_data.temperature_deg, out_data.reading_ok,
                             out_data.value_held);
            end
            else
            begin
                want = expected_readings.pop_front();
                if (out_data.temperature_deg !== want.temperature_deg ||
                    out_data.reading_ok !== want.reading_ok ||
                    out_data.value_held !== want.value_held)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
                                 want.temperature_deg, want.reading_ok, want.value_held,
                                 out_data.temperature_deg, out_data.reading_ok,
                                 out_data.value_held);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || in_fire || out_fire)
            stuck_cycles <= 0;
        else if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic queue_read(input logic [7:0] status, input logic [7:0] low,
                              input logic failed);
        stsc_pkg::in_item_t rd;
        rd.status_byte = status;
        rd.low_byte    = low;
        rd.bus_failed  = failed;
        pending_reads.push_back(rd);
    endtask

    task automatic queue_random_reads(input int count, input int fail_pct);
        logic [7:0] status;
        logic [7:0] low;
        int         code;
        for (int i = 0; i < count; i++)
        begin
            status = 8'($urandom);
            low    = 8'($urandom);
            if ($urandom_range(0, 99) < fail_pct)
            begin
                if ($urandom_range(0, 1) == 1)
                    queue_read(status, low, 1'b1);
                else
                begin
                    status[stsc_pkg::STATUS_OK_BIT] = 1'b0;
                    queue_read(status, low, 1'($urandom));
                end
            end
            else
            begin
                status[stsc_pkg::STATUS_OK_BIT] = 1'b1;
                // cluster around the zero crossing and the low out-of-range edge
                if ($urandom_range(0, 2) == 0)
                begin
                    code        = $urandom_range(140, 190);
                    status[1:0] = 2'(code >> 8);
                    low         = 8'(code);
                end
                queue_read(status, low, 1'b0);
            end
        end
    endtask

    task automatic wait_until_idle();
        while (pending_reads.size() != 0 || in_valid || expected_readings.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_hold_limit(input logic [stsc_pkg::HOLD_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    int phase_limit[6];
    int phase_fail_pct[6];

    initial
    begin
        phase_limit    = '{0, 3, 255, 1, 0, 20};
        phase_fail_pct = '{30, 60, 40, 50, 25, 70};
        phase_limit[4] = $urandom_range(2, 254);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: failures, code extremes, junk status bits, zero crossing
        queue_read(8'h80, 8'h00, 1'b1);
        queue_read(8'h7F, 8'hFF, 1'b0);
        queue_read(8'h00, 8'h00, 1'b1);
        queue_read(8'h80, 8'h00, 1'b0);
        queue_read(8'hFF, 8'hFF, 1'b0);
        queue_read(8'hFC, 8'hA4, 1'b0);
        for (int c = 158; c <= 170; c++)
            queue_read(8'h80, 8'(c), 1'b0);
        queue_read(8'h81, 8'h00, 1'b0);
        repeat (3) queue_read(8'h83, 8'h55, 1'b1);
        queue_read(8'h83, 8'h55, 1'b0);
        wait_until_idle();

        for (int p = 0; p < 6; p++)
        begin
            write_hold_limit(phase_limit[p][stsc_pkg::HOLD_W-1:0]);
            queue_random_reads(275, phase_fail_pct[p]);
            wait_until_idle();
        end

        repeat (30) @(posedge clk);
        if (errors == 0 && expected_readings.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
